// ===== hdl/ifa_pkg.sv =====
// Package: shared types and constants for the id-filtered average block.
package ifa_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);
  localparam int unsigned StepW   = $clog2(DataW);

  typedef struct packed {
    logic [DataW-1:0] sum;
    logic [DataW-1:0] count;
  } job_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

// ===== hdl/ifa_front.sv =====
// Front end: accepts entry beats, filters by target id, accumulates, queues a job per data set.
module ifa_front
  import ifa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [DataW-1:0] cfg_target_id,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DataW-1:0] in_entry_id,
  input  logic [DataW-1:0] in_entry_value,
  input  logic             in_last_entry,
  output hs_t              push_hs,
  input  logic             push_ready,
  output job_t             push_job
);

  logic [DataW-1:0] target_r, target_nxt;
  logic [DataW-1:0] sum_r, sum_nxt;
  logic [DataW-1:0] count_r, count_nxt;
  logic [DataW-1:0] sum_upd, count_upd;
  logic             hit, accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign hit      = (in_entry_id == target_r);

  always_comb begin
    sum_upd   = hit ? sum_r + in_entry_value : sum_r;
    count_upd = hit ? count_r + DataW'(1) : count_r;
  end

  assign push_hs.valid = accept && in_last_entry;
  assign push_hs.ready = push_ready;
  assign push_job.sum   = sum_upd;
  assign push_job.count = count_upd;

  always_comb begin
    target_nxt = cfg_valid ? cfg_target_id : target_r;
    sum_nxt    = sum_r;
    count_nxt  = count_r;
    if (accept) begin
      sum_nxt   = in_last_entry ? '0 : sum_upd;
      count_nxt = in_last_entry ? '0 : count_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      sum_r    <= '0;
      count_r  <= '0;
    end else begin
      target_r <= target_nxt;
      sum_r    <= sum_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/ifa_queue.sv =====
// Short job queue between the accumulating front end and the divider.
module ifa_queue
  import ifa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  hs_t  push_hs,
  input  job_t push_job,
  output logic push_ready,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t             mem_r [QDepth];
  logic [QPtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != QCntW'(QDepth));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem_r[rd_r];
  assign do_push    = push_hs.valid && push_hs.ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_nxt  = do_push ? ((wr_r == QPtrW'(QDepth - 1)) ? '0 : wr_r + QPtrW'(1)) : wr_r;
    rd_nxt  = do_pop  ? ((rd_r == QPtrW'(QDepth - 1)) ? '0 : rd_r + QPtrW'(1)) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/ifa_back.sv =====
// Back end: radix-2 restoring divider and output register for the average.
module ifa_back
  import ifa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  job_t             pop_job,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DataW-1:0] out_average
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [DataW-1:0] rem_r, rem_nxt;
  logic [DataW-1:0] quo_r, quo_nxt;
  logic [DataW-1:0] div_r, div_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic             ovld_r, ovld_nxt;
  logic [DataW-1:0] oavg_r, oavg_nxt;
  logic [DataW:0]   trial, diff;
  logic             out_free;

  assign out_free    = !ovld_r || out_ready;
  assign out_valid   = ovld_r;
  assign out_average = oavg_r;
  assign pop_ready   = (state_r == S_IDLE);

  assign trial = {rem_r, quo_r[DataW-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    div_nxt   = div_r;
    step_nxt  = step_r;
    ovld_nxt  = ovld_r && !out_ready;
    oavg_nxt  = oavg_r;
    unique case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          rem_nxt  = '0;
          quo_nxt  = (pop_job.count == '0) ? '0 : pop_job.sum;
          div_nxt  = pop_job.count;
          step_nxt = '0;
          state_nxt = (pop_job.count == '0) ? S_DONE : S_DIV;
        end
      end
      S_DIV: begin
        // one quotient bit a cycle, MSB first
        if (!diff[DataW]) begin
          rem_nxt = diff[DataW-1:0];
          quo_nxt = {quo_r[DataW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DataW-1:0];
          quo_nxt = {quo_r[DataW-2:0], 1'b0};
        end
        step_nxt = step_r + StepW'(1);
        if (step_r == StepW'(DataW - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          oavg_nxt  = quo_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    div_r  <= div_nxt;
    step_r <= step_nxt;
    oavg_r <= oavg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

// ===== hdl/id_filtered_average.sv =====
// Top level: id-filtered running average over data sets of (id, value) entries.
//
// Channels: in_* carries one entry per beat (id, value, last flag); out_*
// carries one average per data set; cfg_* writes the 32-bit target id and is
// always ready. Write the target id only while the block is idle.
// Entries are taken one per cycle while the job queue has room. An entry whose id equals the target adds
// its value to a 32-bit wrapping sum and bumps a match count. The beat with
// in_last_entry set closes the set: sum and count go into a two-deep job
// queue and the accumulators clear in the same cycle, so the next set can
// start right away.
// The back end divides with a restoring divider, one quotient bit per cycle,
// and registers each set's average (0 when nothing matched). The divider
// sets the rate for closing beats: it takes the next job from the queue
// only once the last result is in the output register; plain beats keep
// flowing at one per cycle until the queue fills.
// Reset (rst_n low, synchronous) clears the target id, accumulators, queue
// and the output valid flag. If the receiver stalls, the result holds in the
// output register, the divider holds its finished quotient, and in_ready
// drops once the queue is full.
module id_filtered_average
  import ifa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [DataW-1:0] cfg_target_id,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DataW-1:0] in_entry_id,
  input  logic [DataW-1:0] in_entry_value,
  input  logic             in_last_entry,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DataW-1:0] out_average
);

  hs_t  push_hs;
  job_t push_job, pop_job;
  logic push_ready, pop_valid, pop_ready;

  assign cfg_ready = 1'b1;

  ifa_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_target_id  (cfg_target_id),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_entry_id    (in_entry_id),
    .in_entry_value (in_entry_value),
    .in_last_entry  (in_last_entry),
    .push_hs        (push_hs),
    .push_ready     (push_ready),
    .push_job       (push_job)
  );

  ifa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_hs    (push_hs),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  ifa_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_job     (pop_job),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_average (out_average)
  );

endmodule

// ===== hdl/ifa_checker.sv =====
// Checker: port-level assertions for the id-filtered average block, bound to the top level.
module ifa_checker
  import ifa_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_last_entry,
  input logic             out_valid,
  input logic             out_ready,
  input logic [DataW-1:0] out_average
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_average))
    else $error("result payload changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_last_entry))
    else $error("input stalled without a closing beat filling the queue");

endmodule

bind id_filtered_average ifa_checker u_ifa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_last_entry (in_last_entry),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_average   (out_average)
);
